// File: design/lzd_pkg.sv
// Package for the LZSS decompressor core: window geometry, parser phases
// and the output beat type. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lzd_pkg;

  // Window geometry and token format
  localparam int LZD_WINDOW_SIZE = 4096;
  localparam int LZD_START_BACK  = 18;  // write position starts this far below the top
  localparam int LZD_MIN_MATCH   = 3;

  // Parser phase
  typedef enum logic [1:0] {
    PH_FLAG,   // expect a flag byte
    PH_TOKEN,  // expect a literal or the low byte of a match
    PH_HIGH,   // expect the match high byte
    PH_COPY    // copying match bytes out of the window
  } phase_t;

  // One decompressed beat
  typedef struct packed {
    logic       last;
    logic [7:0] data;
  } out_beat_t;

endpackage

`default_nettype wire

// File: design/lzd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old data. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module lzd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: design/lzss_decompressor_core.sv
// LZSS decompressor core: stream parser, window memory control, output buffer.
// Depends on lzd_pkg and lzd_ram.
`timescale 1ns / 1ps
`default_nettype none

// Decodes an LZSS stream fed one compressed byte per input beat and emits one
// decompressed byte per output beat. Flag bytes, literals and the low byte of
// a match are each taken as one input beat. The high byte of a match starts a
// copy out of the 4096-byte window that reads one byte per cycle from the
// window RAM read port while the output buffer has room, so a match of length
// L (3..18) holds the input off while it copies. out_tlast marks the last
// byte produced by one input beat. After the input beat with in_tlast set the
// decoder returns to its start state and the window reads back as zeros; this
// is tracked by a fill count, so there is no clearing pass and no dead time.
module lzss_decompressor_core
  import lzd_pkg::*;
#(
  parameter int WINDOW_SIZE = LZD_WINDOW_SIZE
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  // compressed stream
  input  wire logic       in_tvalid,
  output      logic       in_tready,
  input  wire logic [7:0] in_tdata,   // [7:0] in_byte
  input  wire logic       in_tlast,   // in_last
  // decompressed stream
  output      logic       out_tvalid,
  input  wire logic       out_tready,
  output      logic [7:0] out_tdata,  // [7:0] out_byte
  output      logic       out_tlast   // out_last
);

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam logic [AW-1:0] START_POS = AW'(WINDOW_SIZE - LZD_START_BACK);

  // Parser and copy state
  phase_t          phase_r, phase_nxt;
  logic [7:0]      flags_r, flags_nxt;
  logic [2:0]      bidx_r, bidx_nxt;
  logic [7:0]      offlo_r, offlo_nxt;
  logic [AW-1:0]   wp_r, wp_nxt;
  logic [AW:0]     fill_r, fill_nxt;
  logic [AW-1:0]   src_r, src_nxt;
  logic [4:0]      rem_r, rem_nxt;
  logic            end_r, end_nxt;

  // Read pipeline
  logic            inflight_r;
  logic            land_last_r;
  logic            valid_r, valid_nxt;
  logic            fwd_r, fwd_nxt;
  logic [7:0]      fwd_data_r;

  // Output buffer, two entries
  out_beat_t       obuf_r [2];
  logic            wptr_r, rptr_r;
  logic [1:0]      cnt_r;

  // Handshake and control terms
  logic            in_acc, pop, push;
  logic            flag_bit, is_lit, issue, land_final, do_clear;
  logic [2:0]      occ;
  logic [7:0]      land_byte;
  logic            ram_we;
  logic [7:0]      ram_wdata;
  logic [7:0]      ram_q;
  logic [AW-1:0]   rel_pos;
  out_beat_t       push_beat;

  assign in_acc   = in_tvalid && in_tready;
  assign pop      = out_tvalid && out_tready;
  assign flag_bit = flags_r[bidx_r];

  // Byte returned by the window: forwarded, stored, or never written (zero)
  assign land_byte = fwd_r ? fwd_data_r : (valid_r ? ram_q : 8'h00);

  // Next phase
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      PH_TOKEN: begin
        if (in_acc) begin
          if (in_tlast) begin
            phase_nxt = PH_FLAG;
          end else if (flag_bit) begin
            phase_nxt = (bidx_r == 3'd7) ? PH_FLAG : PH_TOKEN;
          end else begin
            phase_nxt = PH_HIGH;
          end
        end
      end
      PH_HIGH: begin
        if (in_acc) begin
          phase_nxt = PH_COPY;
        end
      end
      PH_COPY: begin
        if (inflight_r && land_last_r) begin
          if (end_r) begin
            phase_nxt = PH_FLAG;
          end else begin
            phase_nxt = (bidx_r == 3'd7) ? PH_FLAG : PH_TOKEN;
          end
        end
      end
      default: begin
        if (in_acc && !in_tlast) begin
          phase_nxt = PH_TOKEN;
        end
      end
    endcase
  end

  // Control and datapath
  always_comb begin
    flags_nxt = flags_r;
    bidx_nxt  = bidx_r;
    offlo_nxt = offlo_r;
    wp_nxt    = wp_r;
    fill_nxt  = fill_r;
    src_nxt   = src_r;
    rem_nxt   = rem_r;
    end_nxt   = end_r;

    in_tready  = (phase_r != PH_COPY) && (cnt_r != 2'd2);
    is_lit     = in_acc && (phase_r == PH_TOKEN) && flag_bit;
    land_final = inflight_r && land_last_r;
    do_clear   = (in_acc && in_tlast && (phase_r != PH_HIGH)) || (land_final && end_r);

    // read issue only when the landing byte is sure to find buffer space
    occ   = 3'({1'b0, cnt_r} + {2'b00, inflight_r} - {2'b00, pop});
    issue = (phase_r == PH_COPY) && (rem_r != 5'd0) && (occ <= 3'd1);

    // window write and buffer push: a literal, or a landed copy byte
    ram_we    = is_lit || inflight_r;
    ram_wdata = is_lit ? in_tdata : land_byte;
    push      = ram_we;
    push_beat = '{last: is_lit || land_last_r, data: ram_wdata};

    if (ram_we) begin
      wp_nxt = wp_r + AW'(1);
      if (fill_r != (AW+1)'(WINDOW_SIZE)) begin
        fill_nxt = fill_r + (AW+1)'(1);
      end
    end

    // parser
    if (in_acc) begin
      case (phase_r)
        PH_TOKEN: begin
          if (flag_bit) begin
            bidx_nxt = bidx_r + 3'd1;
          end else begin
            offlo_nxt = in_tdata;
          end
        end
        PH_HIGH: begin
          src_nxt = AW'({in_tdata[7:4], offlo_r});
          rem_nxt = 5'({1'b0, in_tdata[3:0]} + 5'(LZD_MIN_MATCH));
          end_nxt = in_tlast;
        end
        default: begin
          flags_nxt = in_tdata;
          bidx_nxt  = 3'd0;
        end
      endcase
    end

    // copy sequencing
    if (issue) begin
      src_nxt = src_r + AW'(1);
      rem_nxt = rem_r - 5'd1;
    end
    if (land_final && !end_r) begin
      bidx_nxt = bidx_r + 3'd1;
    end

    // end of stream: back to the start state
    if (do_clear) begin
      wp_nxt    = START_POS;
      fill_nxt  = '0;
      flags_nxt = '0;
      bidx_nxt  = '0;
      offlo_nxt = '0;
    end

    // forward a write that hits the address being read in the same cycle
    fwd_nxt   = issue && ram_we && (src_r == wp_r);
    rel_pos   = src_r - START_POS;
    valid_nxt = ({1'b0, rel_pos} < fill_r);
  end

  // Window memory
  lzd_ram #(
    .WIDTH (8),
    .DEPTH (WINDOW_SIZE)
  ) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (ram_wdata),
    .raddr (src_r),
    .rdata (ram_q)
  );

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_FLAG;
      flags_r     <= '0;
      bidx_r      <= '0;
      offlo_r     <= '0;
      wp_r        <= START_POS;
      fill_r      <= '0;
      rem_r       <= '0;
      end_r       <= 1'b0;
      inflight_r  <= 1'b0;
      land_last_r <= 1'b0;
      fwd_r       <= 1'b0;
      valid_r     <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      flags_r     <= flags_nxt;
      bidx_r      <= bidx_nxt;
      offlo_r     <= offlo_nxt;
      wp_r        <= wp_nxt;
      fill_r      <= fill_nxt;
      rem_r       <= rem_nxt;
      end_r       <= end_nxt;
      inflight_r  <= issue;
      land_last_r <= issue && (rem_r == 5'd1);
      fwd_r       <= fwd_nxt;
      valid_r     <= valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    src_r      <= src_nxt;
    fwd_data_r <= ram_wdata;
    if (push) begin
      obuf_r[wptr_r] <= push_beat;
    end
  end

  // Output buffer pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      if (push) begin
        wptr_r <= ~wptr_r;
      end
      if (pop) begin
        rptr_r <= ~rptr_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = obuf_r[rptr_r].data;
  assign out_tlast  = obuf_r[rptr_r].last;

  // Checks
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && (cnt_r == 2'd2) && !pop))
    else $error("output buffer overflow");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= (AW+1)'(WINDOW_SIZE))
    else $error("fill count beyond window size");

  a_copy_tail: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COPY && rem_r == 5'd0) |-> (inflight_r && land_last_r))
    else $error("copy finished without a final landing byte");

endmodule

`default_nettype wire

// File: tb/sv/lzd_stream_checker.sv
// Scoreboard for the LZSS decompressor core: watches both stream channels,
// decodes each accepted compressed beat itself and compares the output beats.
// Depends on lzd_pkg.
`timescale 1ns / 1ps

module lzd_stream_checker
  import lzd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_tvalid,
  input  wire logic       in_tready,
  input  wire logic [7:0] in_tdata,
  input  wire logic       in_tlast,
  input  wire logic       out_tvalid,
  input  wire logic       out_tready,
  input  wire logic [7:0] out_tdata,
  input  wire logic       out_tlast,
  output int              fail_count,
  output int              pending,
  output int              beats_checked
);

  localparam int START_POS = LZD_WINDOW_SIZE - LZD_START_BACK;

  // decoder shadow state
  logic [7:0]  history [LZD_WINDOW_SIZE];
  logic [11:0] wr_pos;
  logic [7:0]  flag_bits;
  logic [2:0]  token_idx;
  phase_t      phase;
  logic [7:0]  off_low;
  out_beat_t   decoded_q[$];

  function automatic void restart_decoder();
    foreach (history[i]) history[i] = 8'h00;
    wr_pos    = 12'(START_POS);
    flag_bits = 8'h00;
    token_idx = 3'd0;
    phase     = PH_FLAG;
    off_low   = 8'h00;
  endfunction

  // every decoded byte lands in the window and in the expected queue
  function automatic void emit_byte(logic [7:0] b, logic l);
    out_beat_t e;
    history[wr_pos] = b;
    wr_pos = wr_pos + 12'd1;
    e.data = b;
    e.last = l;
    decoded_q.push_back(e);
  endfunction

  function automatic void step_token();
    if (token_idx == 3'd7) begin
      token_idx = 3'd0;
      phase     = PH_FLAG;
    end else begin
      token_idx = token_idx + 3'd1;
      phase     = PH_TOKEN;
    end
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic l);
    logic [11:0] src;
    logic [11:0] rd;
    int          len;
    case (phase)
      PH_TOKEN: begin
        if (flag_bits[token_idx]) begin
          emit_byte(b, 1'b1);
          step_token();
        end else begin
          off_low = b;
          phase   = PH_HIGH;
        end
      end
      PH_HIGH: begin
        // byte-by-byte copy, so an overlapping source repeats fresh bytes
        src = {b[7:4], off_low};
        len = b[3:0] + LZD_MIN_MATCH;
        for (int j = 0; j < len; j++) begin
          rd = src + 12'(j);
          emit_byte(history[rd], j == len - 1);
        end
        step_token();
      end
      default: begin
        flag_bits = b;
        token_idx = 3'd0;
        phase     = PH_TOKEN;
      end
    endcase
    if (l) restart_decoder();
  endfunction

  // compare output first; an input beat can't produce output in its own cycle
  always @(posedge clk) begin
    out_beat_t want;
    if (!rst_n) begin
      restart_decoder();
      decoded_q.delete();
      fail_count    = 0;
      beats_checked = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (decoded_q.size() == 0) begin
          fail_count++;
          $error("out_byte: unexpected beat %02h, no decoded byte pending", out_tdata);
        end else begin
          want = decoded_q.pop_front();
          beats_checked++;
          if (out_tdata !== want.data) begin
            fail_count++;
            $error("out_byte: expected %02h, actual %02h", want.data, out_tdata);
          end
          if (out_tlast !== want.last) begin
            fail_count++;
            $error("out_last: expected %0b, actual %0b", want.last, out_tlast);
          end
        end
      end
      if (in_tvalid && in_tready) decode_byte(in_tdata, in_tlast);
    end
    pending = decoded_q.size();
  end

endmodule

// File: tb/sv/tb_lzss_decompressor_core.sv
// Top of the LZSS decompressor testbench: clock, reset, compressed stream
// generation and output back-pressure. Depends on lzd_pkg, lzd_stream_checker
// and the core.
`timescale 1ns / 1ps

module tb_lzss_decompressor_core;
  import lzd_pkg::*;

  localparam int START_POS    = LZD_WINDOW_SIZE - LZD_START_BACK;
  localparam int IDLE_PCT     = 15;
  localparam int HOLD_CYCLES  = 300;
  localparam int DRAIN_CYCLES = 40;
  localparam int TARGET_BEATS = 190;

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'h00;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  wire logic  in_tready;
  wire logic  out_tvalid;
  wire logic [7:0] out_tdata;
  wire logic  out_tlast;

  int fail_count;
  int pending;
  int beats_checked;
  int beats_sent   = 0;
  int streams_sent = 0;
  bit steady       = 1'b0;  // no idling on either side while set
  bit hold_req     = 1'b0;  // ask the receiver for one long hold-off

  logic [7:0] comp_q[$];    // compressed stream under construction

  always #5 clk = ~clk;

  lzss_decompressor_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  lzd_stream_checker u_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tlast      (in_tlast),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .fail_count    (fail_count),
    .pending       (pending),
    .beats_checked (beats_checked)
  );

  // one compressed beat, with random gaps ahead of it
  task automatic send_beat(input logic [7:0] b, input logic l);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= l;
    do @(posedge clk); while (!in_tready);
    beats_sent++;
  endtask

  task automatic send_stream();
    foreach (comp_q[i]) send_beat(comp_q[i], i == comp_q.size() - 1);
    comp_q.delete();
    streams_sent++;
  endtask

  // Mostly well-formed streams: most matches point back into bytes this stream
  // already produced; a few are raw noise or end on one extra dangling byte.
  task automatic build_stream(input int n_tokens);
    logic [7:0]  flags;
    logic [11:0] pos;
    logic [11:0] off;
    logic [3:0]  len_code;
    int          written;
    int          back;
    int          kind;
    kind    = (n_tokens > 30) ? 19 : $urandom_range(0, 19);
    pos     = 12'(START_POS);
    written = 0;
    flags   = 8'h00;
    if (kind < 2) begin
      repeat ($urandom_range(1, 12)) comp_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      for (int t = 0; t < n_tokens; t++) begin
        if (t % 8 == 0) begin
          flags = 8'($urandom_range(0, 255));
          comp_q.push_back(flags);
        end
        if (flags[t % 8]) begin
          comp_q.push_back(8'($urandom_range(0, 255)));
          pos = pos + 12'd1;
          written++;
        end else begin
          len_code = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15))
                                                 : 4'($urandom_range(0, 4));
          if (written > 0 && $urandom_range(0, 4) != 0) begin
            back = $urandom_range(1, (written < 300) ? written : 300);
            off  = pos - 12'(back);
          end else begin
            off = 12'($urandom_range(0, 4095));
          end
          comp_q.push_back(off[7:0]);
          comp_q.push_back({off[11:8], len_code});
          pos     = pos + 12'(len_code) + 12'd3;
          written = written + len_code + 3;
        end
      end
      // dangling flag byte, extra literal or truncated match at the end
      if (kind < 5) comp_q.push_back(8'($urandom_range(0, 255)));
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // literal, max-length overlapping match, offsets 0 and 0xfff, cut-short end
    comp_q = '{8'h01, 8'hFF, 8'hEE, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'hF7, 8'h12};
    send_stream();
    // window must read back zeros after the previous stream; ends on a match
    comp_q = '{8'h00, 8'hEE, 8'hF0, 8'h34, 8'h5F};
    send_stream();
    // stream that is only a flag byte
    comp_q = '{8'hAA};
    send_stream();
    // literals only, ends on a literal
    comp_q = '{8'hFF, 8'h00, 8'h80, 8'h7F};
    send_stream();

    // random streams
    while (beats_sent < TARGET_BEATS) begin
      case (streams_sent)
        6:  hold_req = 1'b1;
        8:  steady   = 1'b1;
        10: steady   = 1'b0;
        default: ;
      endcase
      if (streams_sent == 7) begin
        // let the decoder run dry before going on
        in_tvalid <= 1'b0;
        @(posedge clk);
        wait (pending == 0);
      end
      build_stream((streams_sent == 6) ? 40 : $urandom_range(1, 24));
      send_stream();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Decoded %0d streams from %0d compressed beats, %0d output beats compared.",
             streams_sent, beats_sent, beats_checked);
    $display("Literals, overlapping and wrapping matches, truncated ends and stalls exercised.");
    if (fail_count == 0 && pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// File: filelist.f
design/lzd_pkg.sv
design/lzd_ram.sv
design/lzss_decompressor_core.sv
tb/sv/lzd_stream_checker.sv
tb/sv/tb_lzss_decompressor_core.sv
